>>> design/gzci_pkg.sv
package gzci_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_LEFT_OFFSET  = 3'd0,
    REG_LOWER_OFFSET = 3'd1,
    REG_X_STEP       = 3'd2,
    REG_Y_STEP       = 3'd3,
    REG_COLUMN_COUNT = 3'd4,
    REG_ROW_COUNT    = 3'd5
  } reg_idx_e;

  localparam int unsigned CountW = 22;

  // one edge job handed from the front to the back
  typedef struct packed {
    logic        dir;       // 0 vertical, 1 horizontal
    logic        falling;
    logic [15:0] mag_num;   // |a| for rising, |b| for falling
    logic [16:0] mag_den;   // |a| + |b|
    logic [16:0] k;         // edge index
    logic [16:0] other;     // index on the other axis
    logic        last;
    logic        fresh;     // first job since a grid start, count restarts
  } edge_job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_OUT
  } back_state_e;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    logic [16:0] t;
    t = 17'h10000 - {1'b0, v};
    return v[15] ? t[15:0] : v;
  endfunction

endpackage

>>> design/grid_zero_crossing_interpolator.sv
// Grid zero-crossing interpolator. Samples arrive column-major; a strict sign
// change against the sample above (vertical edge, direction 0) or the same row
// of the previous column (horizontal edge, direction 1) gives a Q16.16 point,
// vertical first. The front takes one sample at a time through its idle, read
// and emit states, holds the next while a crossing waits, and keeps a one-column
// line buffer; crossings go through a two-entry queue to the back, which takes
// one crossing at a time: a 16-step bit-serial divider for the fraction and
// four passes of one 32x17 multiplier for the scaling. Any register write
// restarts the scan at row 0, column 0.
module grid_zero_crossing_interpolator #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] point_x_o,
  output logic [31:0] point_y_o,
  output logic        edge_direction_o,
  output logic [21:0] crossing_total_o,
  output logic        last_of_run_o
);
  import gzci_pkg::*;

  logic [31:0] left_q, lower_q, xs_q, ys_q;
  logic [10:0] ccnt_q, rcnt_q;
  logic        wr_en, restart;
  reg_idx_e    widx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign widx    = reg_idx_e'(paddr[4:2]);
  assign restart = wr_en && (paddr[4:2] <= 3'(REG_ROW_COUNT));

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      lower_q <= '0;
      xs_q    <= 32'd65536;
      ys_q    <= 32'd65536;
      ccnt_q  <= 11'd1024;
      rcnt_q  <= 11'd1024;
    end else if (wr_en) begin
      case (widx)
        REG_LEFT_OFFSET:  left_q  <= pwdata;
        REG_LOWER_OFFSET: lower_q <= pwdata;
        REG_X_STEP:       xs_q    <= pwdata;
        REG_Y_STEP:       ys_q    <= pwdata;
        REG_COLUMN_COUNT: ccnt_q  <= pwdata[10:0];
        REG_ROW_COUNT:    rcnt_q  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    case (widx)
      REG_LEFT_OFFSET:  prdata = left_q;
      REG_LOWER_OFFSET: prdata = lower_q;
      REG_X_STEP:       prdata = xs_q;
      REG_Y_STEP:       prdata = ys_q;
      REG_COLUMN_COUNT: prdata = {21'd0, ccnt_q};
      REG_ROW_COUNT:    prdata = {21'd0, rcnt_q};
      default:          prdata = '0;
    endcase
  end

  edge_job_t f_job, q_job;
  logic      f_valid, f_ready, q_valid, q_ready;

  gzci_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk_i, .rst_ni,
    .restart_i      (restart),
    .row_count_i    (rcnt_q),
    .column_count_i (ccnt_q),
    .in_valid_i, .in_ready_o, .sample_i,
    .job_valid_o    (f_valid),
    .job_ready_i    (f_ready),
    .job_o          (f_job)
  );

  gzci_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_job)
  );

  gzci_back u_back (
    .clk_i, .rst_ni,
    .restart_i      (restart),
    .left_offset_i  (left_q),
    .lower_offset_i (lower_q),
    .x_step_i       (xs_q),
    .y_step_i       (ys_q),
    .job_valid_i    (q_valid),
    .job_ready_o    (q_ready),
    .job_i          (q_job),
    .out_valid_o, .out_ready_i,
    .point_x_o, .point_y_o, .edge_direction_o, .crossing_total_o, .last_of_run_o
  );
endmodule

>>> design/gzci_front.sv
module gzci_front #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic [10:0]          row_count_i,
  input  logic [10:0]          column_count_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          sample_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output gzci_pkg::edge_job_t  job_o
);
  import gzci_pkg::*;

  localparam int unsigned RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_READ,
    FR_EMIT
  } front_state_e;

  front_state_e state_q, state_d;

  logic [15:0]     line_buf [MAX_ROWS];
  logic [15:0]     buf_rd_q;
  logic [15:0]     prev_q;
  logic [15:0]     above_q;
  logic [15:0]     cur_q;
  logic [RowW-1:0] row_q;
  logic [ColW-1:0] col_q;
  logic [RowW:0]   row_w;
  logic [ColW:0]   col_w;
  logic [16:0]     rows_eff, cols_eff;
  logic [RowW:0]   j_eff;
  logic [ColW:0]   i_eff;
  logic [RowW-1:0] j_q;
  logic [ColW-1:0] i_q;
  logic            vert_pend_q, horz_pend_q;
  logic            fresh_q;
  logic            accept;
  logic            grid_start;

  // clamp counts to 1..MAX
  always_comb begin
    rows_eff = (row_count_i == 11'd0) ? 17'd1 : {6'd0, row_count_i};
    if (rows_eff > 17'(MAX_ROWS)) rows_eff = 17'(MAX_ROWS);
    cols_eff = (column_count_i == 11'd0) ? 17'd1 : {6'd0, column_count_i};
    if (cols_eff > 17'(MAX_COLUMNS)) cols_eff = 17'(MAX_COLUMNS);
    row_w = {1'b0, row_q};
    col_w = {1'b0, col_q};
    j_eff = (17'(row_w) >= rows_eff) ? '0 : row_w;
    i_eff = (17'(col_w) >= cols_eff) ? '0 : col_w;
  end

  assign in_ready_o = (state_q == FR_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // line buffer: read at accept, write with the new sample
  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_rd_q            <= line_buf[j_eff[RowW-1:0]];
      line_buf[j_eff[RowW-1:0]] <= sample_i;
    end
  end

  // crossing detection for pending edges
  logic [15:0] cand_a;
  logic        cand_dir;
  logic        sa_neg, sa_pos, sb_neg, sb_pos, rising, falling, hit;
  logic [15:0] ma, mb;
  always_comb begin
    cand_dir = !vert_pend_q;
    cand_a   = cand_dir ? buf_rd_q : above_q;
    sa_neg   = cand_a[15];
    sa_pos   = !cand_a[15] && (cand_a != 16'd0);
    sb_neg   = cur_q[15];
    sb_pos   = !cur_q[15] && (cur_q != 16'd0);
    rising   = sa_neg && sb_pos;
    falling  = sa_pos && sb_neg;
    hit      = (rising || falling) && (vert_pend_q || horz_pend_q);
    ma       = mag16(cand_a);
    mb       = mag16(cur_q);
  end

  // horizontal edge hit (to know if vertical is last)
  logic h_hit;
  always_comb begin
    h_hit = horz_pend_q &&
            ((buf_rd_q[15] && !cur_q[15] && cur_q != 16'd0) ||
             (!buf_rd_q[15] && buf_rd_q != 16'd0 && cur_q[15]));
  end

  always_comb begin
    job_o.dir     = cand_dir;
    job_o.falling = falling;
    job_o.mag_num = falling ? mb : ma;
    job_o.mag_den = {1'b0, ma} + {1'b0, mb};
    job_o.k       = cand_dir ? 17'(i_q) : 17'(j_q);
    job_o.other   = cand_dir ? 17'(j_q) : 17'(i_q);
    job_o.last    = cand_dir ? 1'b1 : !h_hit;
    job_o.fresh   = fresh_q;
  end

  assign job_valid_o = (state_q == FR_EMIT) && hit;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (accept) state_d = FR_READ;
      FR_READ: state_d = FR_EMIT;
      FR_EMIT: begin
        if (!hit || job_ready_i) begin
          if (!(vert_pend_q && horz_pend_q)) state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  assign grid_start = accept && (i_eff == '0) && (j_eff == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FR_IDLE;
      prev_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      vert_pend_q <= 1'b0;
      horz_pend_q <= 1'b0;
      fresh_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (restart_i) begin
        row_q <= '0;
        col_q <= '0;
      end else if (accept) begin
        prev_q      <= sample_i;
        vert_pend_q <= (j_eff != '0);
        horz_pend_q <= (i_eff != '0);
        if (17'(j_eff) + 17'd1 >= rows_eff) begin
          row_q <= '0;
          col_q <= (17'(i_eff) + 17'd1 >= cols_eff) ? '0 : ColW'(i_eff + 1'b1);
        end else begin
          row_q <= RowW'(j_eff + 1'b1);
          col_q <= i_eff[ColW-1:0];
        end
      end
      if (state_q == FR_EMIT && (!hit || job_ready_i)) begin
        if (vert_pend_q) vert_pend_q <= 1'b0;
        else             horz_pend_q <= 1'b0;
      end
      // mark the first job after a grid start so the back restarts its count
      if (grid_start) fresh_q <= 1'b1;
      else if (job_valid_o && job_ready_i) fresh_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q   <= sample_i;
      above_q <= prev_q;
      j_q     <= j_eff[RowW-1:0];
      i_q     <= i_eff[ColW-1:0];
    end
  end

  // an item with no crossing still passes through FR_EMIT, which clears pending edges
  // in FR_EMIT with neither pending, hit is false and the state returns to idle
endmodule

>>> design/gzci_queue.sv
module gzci_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  gzci_pkg::edge_job_t wr_data_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output gzci_pkg::edge_job_t rd_data_o
);
  import gzci_pkg::*;

  // two-entry fifo
  edge_job_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= !wp_q;
      if (do_rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule

>>> design/gzci_back.sv
module gzci_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic [31:0]         left_offset_i,
  input  logic [31:0]         lower_offset_i,
  input  logic [31:0]         x_step_i,
  input  logic [31:0]         y_step_i,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  gzci_pkg::edge_job_t job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         point_x_o,
  output logic [31:0]         point_y_o,
  output logic                edge_direction_o,
  output logic [21:0]         crossing_total_o,
  output logic                last_of_run_o
);
  import gzci_pkg::*;

  back_state_e state_q, state_d;
  edge_job_t   job_q;
  logic [32:0] rem_q;     // restoring divider remainder
  logic [16:0] quo_q;
  logic [4:0]  cnt_q;
  logic [1:0]  mstep_q;
  logic [32:0] pos_q;     // Q16.16 position, up to 17 integer bits
  logic [32:0] opos_q;
  logic [63:0] acc_q;
  logic [31:0] px_q, py_q;
  logic        dir_q, last_q;
  logic [21:0] count_q;

  // restoring division step: quotient of num*65536/den, one bit a cycle
  logic [33:0] trial;
  assign trial = {rem_q, 1'b0} - {17'd0, job_q.mag_den};

  // shared 32x17 multiply on signed step, position split into two halves
  logic [31:0]        mstep;
  logic [16:0]        mpart;
  logic signed [49:0] prod;
  always_comb begin
    mstep = (mstep_q[1] ? !job_q.dir : job_q.dir) ? x_step_i : y_step_i;
    case (mstep_q)
      2'd0: mpart = {1'b0, pos_q[15:0]};
      2'd1: mpart = pos_q[32:16];
      2'd2: mpart = {1'b0, opos_q[15:0]};
      default: mpart = opos_q[32:16];
    endcase
    prod = $signed(mstep) * $signed({1'b0, mpart});
  end

  assign job_ready_o = (state_q == BK_IDLE);
  assign out_valid_o = (state_q == BK_OUT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (job_valid_i) state_d = BK_DIV;
      BK_DIV:  if (cnt_q == 5'd15) state_d = BK_MUL;
      BK_MUL:  if (mstep_q == 2'd3) state_d = BK_OUT;
      BK_OUT:  if (out_ready_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  logic [16:0] frac;
  assign frac = trial[33] ? {quo_q[15:0], 1'b0} : {quo_q[15:0], 1'b1};

  logic [63:0] acc_next;
  always_comb begin
    case (mstep_q)
      2'd0, 2'd2: acc_next = 64'($signed(prod));
      default:    acc_next = acc_q + {prod[47:0], 16'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (restart_i) count_q <= '0;
      else if (state_q == BK_IDLE && job_valid_i && job_i.fresh) count_q <= '0;
      else if (state_q == BK_OUT && out_ready_i) count_q <= count_q + 22'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        job_q   <= job_i;
        rem_q   <= {17'd0, job_i.mag_num};
        quo_q   <= '0;
        cnt_q   <= '0;
        mstep_q <= '0;
      end
      BK_DIV: begin
        if (!trial[33]) rem_q <= trial[32:0];
        else            rem_q <= {rem_q[31:0], 1'b0};
        quo_q <= frac;
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          pos_q  <= job_q.falling ?
                    ({job_q.k, 16'd0} - {16'd0, frac}) :
                    ({job_q.k - 17'd1, 16'd0} + {16'd0, frac});
          opos_q <= {job_q.other, 16'd0};
        end
      end
      BK_MUL: begin
        acc_q   <= acc_next;
        mstep_q <= mstep_q + 2'd1;
        if (mstep_q == 2'd1) begin
          if (job_q.dir) px_q <= left_offset_i + acc_next[47:16];
          else           py_q <= lower_offset_i + acc_next[47:16];
        end
        if (mstep_q == 2'd3) begin
          if (job_q.dir) py_q <= lower_offset_i + acc_next[47:16];
          else           px_q <= left_offset_i + acc_next[47:16];
          dir_q  <= job_q.dir;
          last_q <= job_q.last;
        end
      end
      default: ;
    endcase
  end

  assign point_x_o        = px_q;
  assign point_y_o        = py_q;
  assign edge_direction_o = dir_q;
  assign crossing_total_o = count_q + 22'd1;
  assign last_of_run_o    = last_q;
endmodule
